// ===== design/khs_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the key hash server select block
package khs_pkg;

    localparam int MAX_SERVERS = 256;
    localparam int BYTE_W      = 8;
    localparam int SUM_W       = 16;
    localparam int HASH_W      = 32;
    localparam int COUNT_W     = 9;
    localparam int INDEX_W     = 8;
    localparam int STEP_W      = $clog2(HASH_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HASH_W-SUM_W-1:0] HASH_HIGH  = '1;
    localparam logic [STEP_W-1:0]       STEP_LAST  = STEP_W'(HASH_W - 1);
    localparam logic [COUNT_W-1:0]      COUNT_MAX  = COUNT_W'(MAX_SERVERS);

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } back_state_t;

    // 16-bit add with end-around carry
    function automatic logic [SUM_W-1:0] add_ones(
        input logic [SUM_W-1:0] acc,
        input logic [SUM_W-1:0] word
    );
        logic [SUM_W:0] t;
        logic [SUM_W:0] u;
        begin
            t = {1'b0, acc} + {1'b0, word};
            u = {1'b0, t[SUM_W-1:0]} + {{SUM_W{1'b0}}, t[SUM_W]};
            add_ones = u[SUM_W-1:0];
        end
    endfunction

endpackage

// ===== design/khs_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces of the key hash server select block
interface khs_byte_if import khs_pkg::*;;
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  key_byte;
    logic               last_byte;
    modport source (output valid, output key_byte, output last_byte, input ready);
    modport sink (input valid, input key_byte, input last_byte, output ready);
endinterface

interface khs_result_if import khs_pkg::*;;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] server_index;
    logic               no_server;
    modport source (output valid, output server_index, output no_server, input ready);
    modport sink (input valid, input server_index, input no_server, output ready);
endinterface

interface khs_cfg_if import khs_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] server_count;
    modport source (output valid, output server_count, input ready);
    modport sink (input valid, input server_count, output ready);
endinterface

interface khs_sum_if import khs_pkg::*;;
    logic               valid;
    logic               ready;
    logic [SUM_W-1:0]   sum;
    modport source (output valid, output sum, input ready);
    modport sink (input valid, input sum, output ready);
endinterface

// ===== design/khs_front.sv =====
`timescale 1ns / 1ps
// front end: pairs key bytes into words and accumulates the ones' complement sum
module khs_front
    import khs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    khs_byte_if.sink      key,
    khs_sum_if.source     sum_out
);

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [BYTE_W-1:0] held_reg;
    logic [BYTE_W-1:0] held_next;
    logic              odd_reg;
    logic              odd_next;
    logic [SUM_W-1:0]  sum_total;
    logic              push;
    logic              accept;

    assign key.ready = sum_out.ready;
    assign accept    = key.valid && key.ready;

    always_comb
    begin
        sum_next  = sum_reg;
        held_next = held_reg;
        odd_next  = odd_reg;
        sum_total = sum_reg;
        push      = 1'b0;
        if (accept)
        begin
            if (!odd_reg)
            begin
                if (!key.last_byte)
                begin
                    held_next = key.key_byte;
                    odd_next  = 1'b1;
                end
                else
                begin
                    sum_total = add_ones(sum_reg, {{(SUM_W-BYTE_W){1'b0}}, key.key_byte});
                    push      = 1'b1;
                end
            end
            else
            begin
                sum_total = add_ones(sum_reg, {key.key_byte, held_reg});
                sum_next  = sum_total;
                held_next = '0;
                odd_next  = 1'b0;
                push      = key.last_byte;
            end
            // end of key clears the accumulator
            if (push)
            begin
                sum_next  = '0;
                held_next = '0;
                odd_next  = 1'b0;
            end
        end
    end

    assign sum_out.valid = push;
    assign sum_out.sum   = sum_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            held_reg <= '0;
            odd_reg  <= 1'b0;
        end
        else
        begin
            sum_reg  <= sum_next;
            held_reg <= held_next;
            odd_reg  <= odd_next;
        end
    end

`ifndef SYNTH
    a_push_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        sum_out.valid |-> (accept && key.last_byte))
        else $error("sum pushed without a last byte");
    a_clear_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        sum_out.valid |=> (sum_reg == '0 && held_reg == '0 && !odd_reg))
        else $error("accumulator not cleared after key end");
    a_held_zero_even: assert property (@(posedge clk) disable iff (!rst_n)
        !odd_reg |-> (held_reg == '0))
        else $error("held byte set in low phase");
`endif

endmodule

// ===== design/khs_queue.sv =====
`timescale 1ns / 1ps
// short queue of finished key sums between front and back end
module khs_queue
    import khs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    khs_sum_if.sink     sum_in,
    khs_sum_if.source   sum_out
);

    logic [SUM_W-1:0]    mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic                push;
    logic                pop;

    assign sum_in.ready  = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign sum_out.valid = (count_reg != '0);
    assign sum_out.sum   = mem[rd_ptr_reg];
    assign push          = sum_in.valid && sum_in.ready;
    assign pop           = sum_out.valid && sum_out.ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= sum_in.sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(sum_in.valid && count_reg == QUEUE_CW'(QUEUE_DEPTH)))
        else $error("push into full queue");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");
`endif

endmodule

// ===== design/khs_back.sv =====
`timescale 1ns / 1ps
// back end: bit-serial hash modulo server count and result register
module khs_back
    import khs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COUNT_W-1:0] server_count,
    khs_sum_if.sink            sum_in,
    khs_result_if.source       result
);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [HASH_W-1:0]  dividend_reg;
    logic [HASH_W-1:0]  dividend_next;
    logic [COUNT_W-1:0] div_reg;
    logic [COUNT_W-1:0] div_next;
    logic [INDEX_W-1:0] rem_reg;
    logic [INDEX_W-1:0] rem_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               none_reg;
    logic               none_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [INDEX_W-1:0] out_index_reg;
    logic [INDEX_W-1:0] out_index_next;
    logic               out_none_reg;
    logic               out_none_next;
    logic [COUNT_W-1:0] count_clamped;
    logic [COUNT_W-1:0] trial;
    logic [COUNT_W-1:0] trial_sub;

    assign count_clamped = (server_count > COUNT_MAX) ? COUNT_MAX : server_count;
    assign trial         = {rem_reg, dividend_reg[HASH_W-1]};
    assign trial_sub     = (trial >= div_reg) ? (trial - div_reg) : trial;

    assign sum_in.ready        = (state_reg == B_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.server_index = out_index_reg;
    assign result.no_server    = out_none_reg;

    always_comb
    begin
        state_next     = state_reg;
        dividend_next  = dividend_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        none_next      = none_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_none_next  = out_none_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            B_IDLE:
            begin
                if (sum_in.valid)
                begin
                    dividend_next = {HASH_HIGH, ~sum_in.sum};
                    div_next      = count_clamped;
                    rem_next      = '0;
                    step_next     = '0;
                    none_next     = (count_clamped == '0);
                    state_next    = (count_clamped == '0) ? B_DONE : B_DIV;
                end
            end
            B_DIV:
            begin
                // one quotient bit per cycle, msb first
                rem_next      = trial_sub[INDEX_W-1:0];
                dividend_next = {dividend_reg[HASH_W-2:0], 1'b0};
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = none_reg ? '0 : rem_reg;
                    out_none_next  = none_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg  <= dividend_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        step_reg      <= step_next;
        none_reg      <= none_next;
        out_index_reg <= out_index_next;
        out_none_reg  <= out_none_next;
    end

`ifndef SYNTH
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> ({1'b0, rem_reg} < div_reg))
        else $error("remainder not below divisor");
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (div_reg != '0 && !none_reg))
        else $error("dividing by zero server count");
    a_none_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_none_reg) |-> (out_index_reg == '0))
        else $error("nonzero index with no server");
`endif

endmodule

// ===== design/key_hash_server_select.sv =====
`timescale 1ns / 1ps
// top level of the key hash server select block
//
//  channel  role  payload                       transaction
//  key      sink  key_byte[7:0], last_byte      one key byte
//  result   src   server_index[7:0], no_server  one server pick per key
//  cfg      sink  server_count[8:0]             server count write
//
// key bytes are taken one per cycle while the queue has room; the ones' complement sum updates in the same cycle
// each key end runs through the back end: load, 32-step bit-serial modulo, unload
// a two-entry queue lets the front end keep taking bytes while the modulo runs
// a zero server count skips the modulo and returns no_server
// reset clears the sum, the queue, the result valid flag and the server count
module key_hash_server_select
    import khs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    khs_byte_if.sink      key,
    khs_result_if.source  result,
    khs_cfg_if.sink       cfg
);

    logic [COUNT_W-1:0] server_count_reg;

    khs_sum_if front_sum ();
    khs_sum_if back_sum ();

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_count_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            server_count_reg <= cfg.server_count;
        end
    end

    khs_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .key     (key),
        .sum_out (front_sum)
    );

    khs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .sum_in  (front_sum),
        .sum_out (back_sum)
    );

    khs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .server_count (server_count_reg),
        .sum_in       (back_sum),
        .result       (result)
    );

endmodule

// ===== test/tb_key_hash_server_select.sv =====
`timescale 1ns / 1ps
// testbench for key_hash_server_select: streams random keys over several server counts
// and checks each server pick against a built-in checksum and modulo predictor
module tb_key_hash_server_select;
    import khs_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 120;
    localparam int PHASE_ITEMS = 200;
    localparam int HOLD_AT     = 700;
    localparam int HOLD_LEN    = 400;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } key_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] server_index;
        logic               no_server;
    } pick_t;

    logic clk;
    logic rst_n;

    khs_byte_if   key_ch ();
    khs_result_if pick_ch ();
    khs_cfg_if    cfg_ch ();

    key_hash_server_select i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    (key_ch),
        .result (pick_ch),
        .cfg    (cfg_ch)
    );

    // predictor state
    logic [SUM_W-1:0]   key_sum;
    logic [BYTE_W-1:0]  held_lo;
    logic               high_half;
    logic [COUNT_W-1:0] count_now;

    key_item_t key_items[$];
    pick_t     picks_due[$];

    int items_queued;
    int items_sent;
    int picks_seen;
    int no_server_seen;
    int clamped_seen;
    int errors;
    int cycles;
    int send_gap;
    int send_calm;
    int recv_gap;
    int recv_calm;
    int hold_left;
    bit hold_done;
    bit key_taken;
    pick_t got;
    pick_t want;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // checksum a key byte; on the last byte compute the expected server pick
    task automatic absorb_key_byte(input logic [BYTE_W-1:0] b, input logic fin);
        logic [SUM_W:0]   t;
        logic [SUM_W-1:0] word;
        logic [HASH_W-1:0] hash;
        logic [HASH_W-1:0] eff;
        logic [HASH_W-1:0] rem;
        pick_t p;
        if (!high_half)
        begin
            if (!fin)
            begin
                held_lo   = b;
                high_half = 1'b1;
                return;
            end
            word = {8'h00, b};
        end
        else
        begin
            word = {b, held_lo};
        end
        t         = {1'b0, key_sum} + {1'b0, word};
        key_sum   = t[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, t[SUM_W]};
        held_lo   = '0;
        high_half = 1'b0;
        if (!fin)
            return;
        hash = {HASH_HIGH, ~key_sum};
        eff  = (count_now > MAX_SERVERS) ? HASH_W'(MAX_SERVERS) : HASH_W'(count_now);
        if (eff == 0)
        begin
            p.server_index = '0;
            p.no_server    = 1'b1;
        end
        else
        begin
            rem            = hash % eff;
            p.server_index = rem[INDEX_W-1:0];
            p.no_server    = 1'b0;
        end
        picks_due.push_back(p);
        key_sum = '0;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fin);
        key_item_t it;
        it.data = b;
        it.last = fin;
        key_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_random_key();
        int len;
        int r;
        logic [BYTE_W-1:0] b;
        r = $urandom_range(0, 99);
        if (r < 70)
            len = $urandom_range(1, 8);
        else if (r < 95)
            len = $urandom_range(9, 32);
        else
            len = $urandom_range(33, 100);
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                b = 8'hff;
            else if (r < 15)
                b = 8'h00;
            else
                b = BYTE_W'($urandom_range(0, 255));
            push_byte(b, i == len - 1);
        end
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] v);
        @(negedge clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.server_count <= v;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        count_now = v;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (items_sent != items_queued || picks_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // key byte driver
    always @(negedge clk)
    begin
        key_item_t it;
        if (!rst_n)
        begin
            key_ch.valid <= 1'b0;
        end
        else if (key_taken || !key_ch.valid)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                key_ch.valid <= 1'b0;
            end
            else if (key_items.size() > 0)
            begin
                it = key_items.pop_front();
                key_ch.valid     <= 1'b1;
                key_ch.key_byte  <= it.data;
                key_ch.last_byte <= it.last;
                send_gap = pick_gap(send_calm);
            end
            else
            begin
                key_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    always @(negedge clk)
    begin
        if (!hold_done && items_sent >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // result ready driver
    always @(negedge clk)
    begin
        if (!rst_n || hold_left > 0)
        begin
            pick_ch.ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            pick_ch.ready <= 1'b0;
        end
        else
        begin
            pick_ch.ready <= 1'b1;
            recv_gap = pick_gap(recv_calm);
        end
    end

    // monitor: key transactions feed the predictor, result transactions are checked
    always @(posedge clk)
    begin
        key_taken = rst_n && key_ch.valid && key_ch.ready;
        if (key_taken)
        begin
            absorb_key_byte(key_ch.key_byte, key_ch.last_byte);
            items_sent++;
        end
        if (rst_n && pick_ch.valid && pick_ch.ready)
        begin
            got.server_index = pick_ch.server_index;
            got.no_server    = pick_ch.no_server;
            picks_seen++;
            if (got.no_server)
                no_server_seen++;
            if (count_now > MAX_SERVERS)
                clamped_seen++;
            if (picks_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transaction, actual index %0d no_server %0b",
                         $time, got.server_index, got.no_server);
            end
            else
            begin
                want = picks_due.pop_front();
                if (got.server_index != want.server_index || got.no_server != want.no_server)
                begin
                    errors++;
                    $display("%0t: mismatch, count %0d, expected %0d/%0b, actual %0d/%0b",
                             $time, count_now, want.server_index, want.no_server,
                             got.server_index, got.no_server);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, picks_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int counts[10];
        counts = '{0, 1, 256, 511, 255, 2, 300, 0, 128, 7};
        counts[7] = $urandom_range(3, 254);
        key_sum        = '0;
        held_lo        = '0;
        high_half      = 1'b0;
        count_now      = '0;
        items_queued   = 0;
        items_sent     = 0;
        picks_seen     = 0;
        no_server_seen = 0;
        clamped_seen   = 0;
        errors         = 0;
        cycles         = 0;
        send_gap       = 0;
        send_calm      = 0;
        recv_gap       = 0;
        recv_calm      = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        key_taken      = 1'b0;
        key_ch.valid        = 1'b0;
        key_ch.key_byte     = '0;
        key_ch.last_byte    = 1'b0;
        pick_ch.ready       = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.server_count = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed keys: single bytes, byte extremes, odd lengths, end-around carry
        write_count(9'd13);
        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b1);
        push_byte(8'hab, 1'b0);
        push_byte(8'hcd, 1'b0);
        push_byte(8'hef, 1'b1);
        push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h01, 1'b1);
        push_byte(8'h55, 1'b0);
        push_byte(8'haa, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7f, 1'b1);
        wait_idle();

        foreach (counts[k])
        begin
            write_count(COUNT_W'(counts[k]));
            while (items_queued < (k + 1) * PHASE_ITEMS + 20)
                push_random_key();
            wait_idle();
        end

        errors += picks_due.size();
        $display("checked %0d server picks from %0d key bytes over %0d server counts",
                 picks_seen, items_sent, $size(counts) + 1);
        $display("%0d picks had no server, %0d ran with a count above the maximum",
                 no_server_seen, clamped_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
